[rtl/dgcm_pkg.sv]
// Package for the dual gain channel merge block.
// Holds the item, result and table entry types, register and code constants,
// and the command/status structs between controller and datapath. No dependencies.
package dgcm_pkg;

	// Item commands
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// Entry gain codes
	localparam logic [1:0] GAIN_HG      = 2'd0;
	localparam logic [1:0] GAIN_LG      = 2'd1;
	localparam logic [1:0] GAIN_LG_ONLY = 2'd2;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_THR    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW_CUT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_RATIO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_MIN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_MAX     = 3'd4;

	// Configuration reset values
	localparam logic [17:0] NOISE_THR_RST    = 18'd48;
	localparam logic [17:0] OVERFLOW_CUT_RST = 18'd15200;
	localparam logic [15:0] GAIN_RATIO_RST   = 16'd4173;
	localparam logic [31:0] TIME_MIN_RST     = 32'hC465_3600;
	localparam logic [31:0] TIME_MAX_RST     = 32'd1000000000;

	// Saturation limit of merged amplitudes
	localparam logic [23:0] AMP_MAX = 24'hFF_FFFF;

	typedef struct packed {
		logic               cmd;
		logic [13:0]        tower_id;
		logic               low_gain;
		logic [17:0]        amplitude;
		logic signed [31:0] fit_time;
		logic signed [31:0] fit_chi2;
		logic [7:0]         fit_ndf;
	} item_t;

	typedef struct packed {
		logic [13:0]        out_tower;
		logic [23:0]        out_amplitude;
		logic signed [31:0] out_time;
		logic signed [31:0] out_chi2;
		logic [7:0]         out_ndf;
		logic               gain_type;
		logic [13:0]        list_index;
	} result_t;

	// One table entry
	typedef struct packed {
		logic        valid;
		logic [1:0]  gain_code;
		logic [23:0] amp;
		logic [31:0] tm;
		logic [31:0] chi2;
		logic [7:0]  ndf;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic clear_step;
		logic commit;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;
		logic emit;
		logic out_full;
	} ctrl_status_t;

endpackage

[rtl/dgcm_ram.sv]
// Generic simple dual port RAM with registered read.
// One write port and one read port with read enable. No dependencies.
module dgcm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, hold data when not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/dgcm_ctrl.sv]
// Controller for the dual gain channel merge block.
// Sequences the clearing pass and the read-modify-write of each item.
// Depends on dgcm_pkg.
module dgcm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  dgcm_pkg::ctrl_status_t status,
	output dgcm_pkg::ctrl_cmd_t    cmd
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       exec_go;

	// Commit unless a result must wait for the output register
	assign exec_go = !(status.emit && status.out_full);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.clear_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (exec_go) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Commands
	assign item_stall     = (state_q != ST_IDLE);
	assign cmd.accept     = (state_q == ST_IDLE) && item_valid;
	assign cmd.clear_step = (state_q == ST_CLEAR);
	assign cmd.commit     = (state_q == ST_EXEC) && exec_go;

endmodule

[rtl/dgcm_dp.sv]
// Datapath for the dual gain channel merge block: configuration registers,
// tower table, gain scaling, merge rules, drain filter and result register.
// Depends on dgcm_pkg and dgcm_ram.
module dgcm_dp #(
	parameter int unsigned NUM_TOWERS = 16384
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dgcm_pkg::item_t                      item,
	input  logic                                 cfg_valid,
	input  logic [dgcm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                          cfg_data,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output dgcm_pkg::result_t                    result,
	input  dgcm_pkg::ctrl_cmd_t                  cmd,
	output dgcm_pkg::ctrl_status_t               status
);

	localparam int unsigned AW = $clog2(NUM_TOWERS);

	// Configuration
	logic [17:0]        noise_thr_q;
	logic [17:0]        overflow_cut_q;
	logic [15:0]        gain_ratio_q;
	logic signed [31:0] time_min_q;
	logic signed [31:0] time_max_q;

	// Item state
	dgcm_pkg::item_t item_s1;
	logic [33:0]     prod_s1;
	logic [AW-1:0]   clr_cnt_q;
	logic [13:0]     kept_count_q;
	logic            result_valid_q;
	dgcm_pkg::result_t result_q;

	// Table ports
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	dgcm_pkg::entry_t     ram_wdata;
	dgcm_pkg::entry_t     ram_rdata;

	// Merge logic
	logic             in_range;
	logic             add_hit;
	logic [34:0]      rnd;
	logic [26:0]      shr;
	logic [23:0]      scaled;
	dgcm_pkg::entry_t new_entry;
	logic             emit;

	// Register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_thr_q    <= dgcm_pkg::NOISE_THR_RST;
			overflow_cut_q <= dgcm_pkg::OVERFLOW_CUT_RST;
			gain_ratio_q   <= dgcm_pkg::GAIN_RATIO_RST;
			time_min_q     <= dgcm_pkg::TIME_MIN_RST;
			time_max_q     <= dgcm_pkg::TIME_MAX_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dgcm_pkg::REG_NOISE_THR:    noise_thr_q    <= cfg_data[17:0];
				dgcm_pkg::REG_OVERFLOW_CUT: overflow_cut_q <= cfg_data[17:0];
				dgcm_pkg::REG_GAIN_RATIO:   gain_ratio_q   <= cfg_data[15:0];
				dgcm_pkg::REG_TIME_MIN:     time_min_q     <= cfg_data;
				dgcm_pkg::REG_TIME_MAX:     time_max_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Latch item and low gain product at accept
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_s1 <= item;
			prod_s1 <= {16'b0, item.amplitude} * {18'b0, gain_ratio_q};
		end
	end

	// Clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_step) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	assign status.clear_last = (clr_cnt_q == AW'(NUM_TOWERS - 1));

	// Round half up, drop fraction, saturate
	assign rnd    = {1'b0, prod_s1} + 35'd128;
	assign shr    = rnd[34:8];
	assign scaled = (shr > {3'b0, dgcm_pkg::AMP_MAX}) ? dgcm_pkg::AMP_MAX : shr[23:0];

	assign in_range = ({18'b0, item_s1.tower_id} < 32'(NUM_TOWERS));
	assign add_hit  = (item_s1.cmd == dgcm_pkg::CMD_ADD) && in_range
		&& (item_s1.amplitude >= noise_thr_q);

	// Merge rules for an add
	always_comb begin
		new_entry = ram_rdata;
		if (!ram_rdata.valid) begin
			new_entry.valid = 1'b1;
			new_entry.gain_code = item_s1.low_gain ? dgcm_pkg::GAIN_LG_ONLY
				: dgcm_pkg::GAIN_HG;
			new_entry.amp  = item_s1.low_gain ? scaled : {6'b0, item_s1.amplitude};
			new_entry.tm   = item_s1.fit_time;
			new_entry.chi2 = item_s1.fit_chi2;
			new_entry.ndf  = item_s1.fit_ndf;
		end else if (item_s1.low_gain) begin
			if (ram_rdata.amp > {6'b0, overflow_cut_q}) begin
				new_entry.amp       = scaled;
				new_entry.tm        = item_s1.fit_time;
				new_entry.gain_code = dgcm_pkg::GAIN_LG;
			end
		end else if (item_s1.amplitude < overflow_cut_q) begin
			new_entry.amp       = {6'b0, item_s1.amplitude};
			new_entry.tm        = item_s1.fit_time;
			new_entry.gain_code = dgcm_pkg::GAIN_HG;
		end else begin
			new_entry.gain_code = dgcm_pkg::GAIN_LG;
		end
	end

	// Drain filter: valid, not low-gain-only, time in window, chi2 not negative
	assign emit = (item_s1.cmd == dgcm_pkg::CMD_DRAIN) && in_range && ram_rdata.valid
		&& (ram_rdata.gain_code != dgcm_pkg::GAIN_LG_ONLY)
		&& ($signed(ram_rdata.tm) >= time_min_q)
		&& ($signed(ram_rdata.tm) <= time_max_q)
		&& !ram_rdata.chi2[31];

	assign status.emit     = emit;
	assign status.out_full = result_valid_q && result_stall;

	// Table write: clearing pass, add merge, drain clear
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(item_s1.tower_id);
		ram_wdata = new_entry;
		if (cmd.clear_step) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else if (cmd.commit) begin
			if (item_s1.cmd == dgcm_pkg::CMD_DRAIN) begin
				ram_we    = in_range;
				ram_wdata = '0;
			end else begin
				ram_we = add_hit;
			end
		end
	end

	dgcm_ram #(
		.WIDTH ($bits(dgcm_pkg::entry_t)),
		.DEPTH (NUM_TOWERS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.accept),
		.raddr (AW'(item.tower_id)),
		.rdata (ram_rdata)
	);

	// Running count of kept entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_count_q <= '0;
		end else if (cmd.commit) begin
			if (item_s1.cmd == dgcm_pkg::CMD_ADD) begin
				kept_count_q <= '0;
			end else if (emit) begin
				kept_count_q <= kept_count_q + 14'd1;
			end
		end
	end

	// Output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.commit && emit) begin
			result_valid_q <= 1'b1;
		end else if (result_valid_q && !result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && emit) begin
			result_q.out_tower     <= item_s1.tower_id;
			result_q.out_amplitude <= ram_rdata.amp;
			result_q.out_time      <= ram_rdata.tm;
			result_q.out_chi2      <= ram_rdata.chi2;
			result_q.out_ndf       <= ram_rdata.ndf;
			result_q.gain_type     <= (ram_rdata.gain_code == dgcm_pkg::GAIN_LG);
			result_q.list_index    <= kept_count_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[rtl/dual_gain_channel_merge_top.sv]
// Top level of the dual gain channel merge block.
// Instantiates dgcm_ctrl and dgcm_dp; depends on dgcm_pkg.
//
// Usage:
//   item channel (item_valid, item_stall, item): add a fit result (cmd add)
//   or drain and clear one tower entry (cmd drain). An item is taken at an
//   edge with item_valid high and item_stall low.
//   result channel (result_valid, result_stall, result): at most one result
//   per drain, held in an output register until taken.
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data): register writes,
//   always ready; write only while no item is in flight.
// Item flow: each item is a read-modify-write of the single tower table
//   memory (read at accept, write at commit); the result register loads
//   at the same edge as that write.
// Reset: the table is swept clear, one entry a cycle, over every entry;
//   item_stall stays high during the sweep. Registers take their defaults.
// Receiver stall: the output register holds its result; a drain that would
//   emit while it is full and stalled waits, and item_stall stays high.
module dual_gain_channel_merge_top #(
	parameter int unsigned NUM_TOWERS = 16384
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  dgcm_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output dgcm_pkg::result_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dgcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	dgcm_pkg::ctrl_cmd_t    cmd;
	dgcm_pkg::ctrl_status_t status;

	assign cfg_ready = 1'b1;

	dgcm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	dgcm_dp #(
		.NUM_TOWERS (NUM_TOWERS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cmd          (cmd),
		.status       (status)
	);

endmodule
